[rtl/core/dssm_pkg.sv]
package dssm_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_ONE = 3'd0,
        OP_POP_ONE  = 3'd1,
        OP_LIST_ONE = 3'd2,
        OP_PUSH_TWO = 3'd3,
        OP_POP_TWO  = 3'd4,
        OP_LIST_TWO = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        addr;
        logic signed [WORD_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic                     last;
    } res_t;

endpackage

[rtl/core/dssm_ram.sv]
module dssm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/dssm_ctrl.sv]
module dssm_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_operation,
    input  logic signed [dssm_pkg::WORD_W-1:0] s_push_value,
    output logic                               res_valid,
    input  logic                               res_ready,
    output dssm_pkg::res_t                     res,
    output dssm_pkg::mem_req_t                 mem_req,
    input  logic signed [dssm_pkg::WORD_W-1:0] mem_rdata
);

    localparam int ADDR_W = dssm_pkg::ADDR_W;
    localparam int CNT_W  = dssm_pkg::CNT_W;
    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(dssm_pkg::DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(dssm_pkg::DEPTH);

    typedef enum logic [1:0] {
        IDLE,
        RDWAIT,
        EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   lower_count_reg;
    logic [CNT_W-1:0]   upper_count_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               list_reg;
    logic               list_up_reg;
    dssm_pkg::res_t     res_reg;

    logic               full;
    logic [CNT_W:0]     used;
    logic [CNT_W-1:0]   lower_dec;
    logic [CNT_W-1:0]   upper_pop;
    logic [ADDR_W-1:0]  addr_next;

    assign used      = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full      = used >= {1'b0, DEPTH_C};
    assign lower_dec = lower_count_reg - CNT_W'(1);
    assign upper_pop = DEPTH_C - upper_count_reg;
    assign addr_next = list_up_reg ? addr_reg + ADDR_W'(1) : addr_reg - ADDR_W'(1);

    assign s_ready   = (state_reg == IDLE);
    assign res_valid = (state_reg == EMIT);
    assign res       = res_reg;

    always_comb begin
        mem_req       = '0;
        mem_req.wdata = s_push_value;
        mem_req.addr  = addr_next;
        if (state_reg == IDLE) begin
            unique case (dssm_pkg::op_t'(s_operation))
                dssm_pkg::OP_PUSH_ONE: begin
                    mem_req.we   = s_valid && !full;
                    mem_req.addr = lower_count_reg[ADDR_W-1:0];
                end
                dssm_pkg::OP_POP_ONE: begin
                    mem_req.addr = lower_dec[ADDR_W-1:0];
                end
                dssm_pkg::OP_LIST_ONE: begin
                    mem_req.addr = '0;
                end
                dssm_pkg::OP_PUSH_TWO: begin
                    mem_req.we   = s_valid && !full;
                    mem_req.addr = TOP_ADDR - upper_count_reg[ADDR_W-1:0];
                end
                dssm_pkg::OP_POP_TWO: begin
                    mem_req.addr = upper_pop[ADDR_W-1:0];
                end
                dssm_pkg::OP_LIST_TWO: begin
                    mem_req.addr = TOP_ADDR;
                end
                default: begin
                    mem_req.addr = addr_next;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= IDLE;
            lower_count_reg <= '0;
            upper_count_reg <= '0;
            list_reg        <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        unique case (dssm_pkg::op_t'(s_operation))
                            dssm_pkg::OP_PUSH_ONE, dssm_pkg::OP_PUSH_TWO: begin
                                state_reg <= EMIT;
                                if (full) begin
                                    res_reg <= '{data: '0, status: dssm_pkg::ST_OVERFLOW,
                                                 last: 1'b1};
                                end else begin
                                    res_reg <= '{data: s_push_value, status: dssm_pkg::ST_OK,
                                                 last: 1'b1};
                                    if (s_operation == dssm_pkg::OP_PUSH_ONE) begin
                                        lower_count_reg <= lower_count_reg + CNT_W'(1);
                                    end else begin
                                        upper_count_reg <= upper_count_reg + CNT_W'(1);
                                    end
                                end
                            end
                            dssm_pkg::OP_POP_ONE: begin
                                if (lower_count_reg == '0) begin
                                    res_reg   <= '{data: '0, status: dssm_pkg::ST_UNDERFLOW,
                                                   last: 1'b1};
                                    state_reg <= EMIT;
                                end else begin
                                    res_reg.status  <= dssm_pkg::ST_OK;
                                    res_reg.last    <= 1'b1;
                                    lower_count_reg <= lower_dec;
                                    state_reg       <= RDWAIT;
                                end
                            end
                            dssm_pkg::OP_POP_TWO: begin
                                if (upper_count_reg == '0) begin
                                    res_reg   <= '{data: '0, status: dssm_pkg::ST_UNDERFLOW,
                                                   last: 1'b1};
                                    state_reg <= EMIT;
                                end else begin
                                    res_reg.status  <= dssm_pkg::ST_OK;
                                    res_reg.last    <= 1'b1;
                                    upper_count_reg <= upper_count_reg - CNT_W'(1);
                                    state_reg       <= RDWAIT;
                                end
                            end
                            dssm_pkg::OP_LIST_ONE: begin
                                if (lower_count_reg == '0) begin
                                    res_reg   <= '{data: '0, status: dssm_pkg::ST_EMPTY,
                                                   last: 1'b1};
                                    state_reg <= EMIT;
                                end else begin
                                    res_reg.status <= dssm_pkg::ST_OK;
                                    res_reg.last   <= (lower_count_reg == CNT_W'(1));
                                    list_reg       <= 1'b1;
                                    list_up_reg    <= 1'b1;
                                    addr_reg       <= '0;
                                    rem_reg        <= lower_count_reg;
                                    state_reg      <= RDWAIT;
                                end
                            end
                            dssm_pkg::OP_LIST_TWO: begin
                                if (upper_count_reg == '0) begin
                                    res_reg   <= '{data: '0, status: dssm_pkg::ST_EMPTY,
                                                   last: 1'b1};
                                    state_reg <= EMIT;
                                end else begin
                                    res_reg.status <= dssm_pkg::ST_OK;
                                    res_reg.last   <= (upper_count_reg == CNT_W'(1));
                                    list_reg       <= 1'b1;
                                    list_up_reg    <= 1'b0;
                                    addr_reg       <= TOP_ADDR;
                                    rem_reg        <= upper_count_reg;
                                    state_reg      <= RDWAIT;
                                end
                            end
                            default: begin
                                state_reg <= IDLE;
                            end
                        endcase
                    end
                end
                RDWAIT: begin
                    res_reg.data <= mem_rdata;
                    state_reg    <= EMIT;
                end
                EMIT: begin
                    if (res_ready) begin
                        if (list_reg && !res_reg.last) begin
                            addr_reg     <= addr_next;
                            rem_reg      <= rem_reg - CNT_W'(1);
                            res_reg.last <= (rem_reg == CNT_W'(2));
                            state_reg    <= RDWAIT;
                        end else begin
                            list_reg  <= 1'b0;
                            state_reg <= IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/dual_stack_shared_memory.sv]
// A push or a failed op goes from IDLE straight to EMIT; a pop reads the RAM in RDWAIT first.
// A new item is taken only in IDLE, after the last result has left EMIT; a list of N words
// does one single-port RAM read and one result register load per word.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) empties both stacks; the RAM contents are not cleared.
module dual_stack_shared_memory (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_operation,
    input  logic signed [dssm_pkg::WORD_W-1:0] s_push_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [dssm_pkg::WORD_W-1:0] m_data_word,
    output logic [1:0]                         m_status,
    output logic                               m_last_of_run
);

    dssm_pkg::mem_req_t                 mem_req;
    logic signed [dssm_pkg::WORD_W-1:0] mem_rdata;
    dssm_pkg::res_t                     res;
    logic                               res_valid;
    logic                               res_ready;

    logic                               m_valid_reg;
    dssm_pkg::res_t                     m_res_reg;

    dssm_ram #(
        .WIDTH (dssm_pkg::WORD_W),
        .DEPTH (dssm_pkg::DEPTH),
        .ADDR_W(dssm_pkg::ADDR_W)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_req.we),
        .addr (mem_req.addr),
        .wdata(mem_req.wdata),
        .rdata(mem_rdata)
    );

    dssm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_push_value(s_push_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_res_reg   <= res;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_word   = m_res_reg.data;
    assign m_status      = m_res_reg.status;
    assign m_last_of_run = m_res_reg.last;

endmodule
